>>> rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared types, constants and functions of the Playfair encipherer
// Holds the letter codes, the key square type, its reset value and the
// square lookup and pair enciphering functions.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned SqN     = 5;
  localparam int unsigned RowW    = SqN * LetterW;
  localparam int unsigned IdxW    = $clog2(SqN);
  localparam int unsigned CfgIdxW = $clog2(SqN);

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [SqN-1:0][RowW-1:0] square_t;

  localparam letter_t LetterX = letter_t'(23);
  localparam letter_t LetterJ = letter_t'(9);
  localparam letter_t LetterI = letter_t'(8);

  // LOVEI / SAMNY / PDRTH / GBCFK / QUWXZ
  localparam square_t SquareReset = {
    RowW'(26991248),
    RowW'(10651686),
    RowW'(7980143),
    RowW'(25604114),
    RowW'(8541643)
  };

  typedef enum logic [CfgIdxW-1:0] {
    RegRow0 = 3'd0,
    RegRow1 = 3'd1,
    RegRow2 = 3'd2,
    RegRow3 = 3'd3,
    RegRow4 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } cell_pos_t;

  // One plaintext pair waiting to be enciphered
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } pair_t;

  typedef struct packed {
    letter_t x;
    letter_t y;
  } cipher_t;

  function automatic logic is_ij(input letter_t v);
    return (v == LetterI) || (v == LetterJ);
  endfunction

  function automatic letter_t cell_at(input square_t sq, input idx_t r, input idx_t c);
    return sq[r][c*LetterW +: LetterW];
  endfunction

  function automatic idx_t wrap_inc(input idx_t v);
    return (v == idx_t'(SqN - 1)) ? '0 : v + idx_t'(1);
  endfunction

  // First match in row-major order: scan backward so the earliest hit wins
  function automatic cell_pos_t find_letter(input square_t sq, input letter_t code);
    cell_pos_t pos;
    pos = '0;
    for (int r = SqN - 1; r >= 0; r--) begin
      for (int c = SqN - 1; c >= 0; c--) begin
        if (sq[r][c*LetterW +: LetterW] == code) begin
          pos.found = 1'b1;
          pos.row   = idx_t'(r);
          pos.col   = idx_t'(c);
        end
      end
    end
    return pos;
  endfunction

  // J falls back to the cell of I; anything not found sits at row 0, column 0
  function automatic cell_pos_t locate(input square_t sq, input letter_t code);
    cell_pos_t pos;
    cell_pos_t pos_i;
    pos   = find_letter(sq, code);
    pos_i = find_letter(sq, LetterI);
    if (!pos.found && (code == LetterJ) && pos_i.found) begin
      pos = pos_i;
    end
    if (!pos.found) begin
      pos = '0;
    end
    return pos;
  endfunction

  function automatic cipher_t encipher(input square_t sq, input letter_t a, input letter_t b);
    cell_pos_t pa;
    cell_pos_t pb;
    cipher_t   res;
    pa = locate(sq, a);
    pb = locate(sq, b);
    if (pa.row == pb.row) begin
      res.x = cell_at(sq, pa.row, wrap_inc(pa.col));
      res.y = cell_at(sq, pb.row, wrap_inc(pb.col));
    end else if (pa.col == pb.col) begin
      res.x = cell_at(sq, wrap_inc(pa.row), pa.col);
      res.y = cell_at(sq, wrap_inc(pb.row), pb.col);
    end else begin
      res.x = cell_at(sq, pb.row, pa.col);
      res.y = cell_at(sq, pa.row, pb.col);
    end
    return res;
  endfunction

endpackage

>>> rtl/playfair_digraph_encipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encipher: Playfair encipherer with a loadable key square
// Plaintext letters go in one per request with a word-end mark; cipher
// letters come out one per request with the last of each word marked.
// ----------------------------------------------------------------------------
// An input letter is taken whenever the two-entry pair queue is empty (or
// its single pair leaves that cycle); letters that only start a pair are
// taken every cycle while the queue is empty. Each plaintext pair is
// enciphered in one pass from the head of the queue into a two-letter output
// register and leaves as two results, first letter then second, so the output
// register sets the pace at which pairs leave the queue; a filler X can add a
// second pair. The key square rows load through the configuration port (index
// 0 to 4, always ready); the user must load them only while the block is
// idle, as the block itself does not enforce this. J is found where I is when
// the square holds no J, and no filler goes between two X letters.
// ----------------------------------------------------------------------------
module playfair_digraph_encipher (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pfe_pkg::RowW-1:0]          cfg_data_i,
  // plaintext
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pfe_pkg::LetterW-1:0]       plain_letter_i,
  input  logic                              word_end_i,
  // ciphertext
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pfe_pkg::LetterW-1:0]       cipher_letter_o,
  output logic                              last_of_word_o
);

  pfe_pkg::square_t square_q;

  pfe_pkg::letter_t held_letter_q, held_letter_d;
  logic             held_valid_q, held_valid_d;
  pfe_pkg::letter_t prev_letter_q, prev_letter_d;
  logic             prev_valid_q, prev_valid_d;

  pfe_pkg::pair_t   pend_q [2];
  logic [1:0]       pend_cnt_q;

  logic             out_valid_q;
  logic             out_idx_q;
  pfe_pkg::letter_t out_x_q, out_y_q;
  logic             out_last_q;

  logic             in_accept;
  logic             filler;
  logic             cipher_free;
  logic             move;
  pfe_pkg::pair_t   pair0, pair1;
  logic [1:0]       npairs;
  pfe_pkg::cipher_t head_cipher;

  // ---- configuration ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q <= pfe_pkg::SquareReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pfe_pkg::RegRow0: square_q[0] <= cfg_data_i;
        pfe_pkg::RegRow1: square_q[1] <= cfg_data_i;
        pfe_pkg::RegRow2: square_q[2] <= cfg_data_i;
        pfe_pkg::RegRow3: square_q[3] <= cfg_data_i;
        pfe_pkg::RegRow4: square_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- handshake ----
  assign cipher_free = !out_valid_q || (out_idx_q && !out_stall_i);
  assign move        = (pend_cnt_q != 2'd0) && cipher_free;
  assign in_stall_o  = !((pend_cnt_q == 2'd0) || ((pend_cnt_q == 2'd1) && move));
  assign in_accept   = in_valid_i && !in_stall_o;

  // ---- digraph building ----
  assign filler = prev_valid_q
                  && ((prev_letter_q == plain_letter_i)
                      || (pfe_pkg::is_ij(prev_letter_q) && pfe_pkg::is_ij(plain_letter_i)))
                  && !((prev_letter_q == pfe_pkg::LetterX) && (plain_letter_i == pfe_pkg::LetterX));

  always_comb begin
    pair0  = '0;
    pair1  = '0;
    npairs = 2'd0;
    if (filler && !held_valid_q) begin
      pair0  = '{a: pfe_pkg::LetterX, b: plain_letter_i, last: word_end_i};
      npairs = 2'd1;
    end else if (filler) begin
      pair0  = '{a: held_letter_q, b: pfe_pkg::LetterX, last: 1'b0};
      pair1  = '{a: plain_letter_i, b: pfe_pkg::LetterX, last: 1'b1};
      npairs = word_end_i ? 2'd2 : 2'd1;
    end else if (held_valid_q) begin
      pair0  = '{a: held_letter_q, b: plain_letter_i, last: word_end_i};
      npairs = 2'd1;
    end else if (word_end_i) begin
      // pad an odd word with X
      pair0  = '{a: plain_letter_i, b: pfe_pkg::LetterX, last: 1'b1};
      npairs = 2'd1;
    end

    held_valid_d  = held_valid_q;
    held_letter_d = held_letter_q;
    prev_valid_d  = prev_valid_q;
    prev_letter_d = prev_letter_q;
    if (in_accept) begin
      held_valid_d  = !word_end_i && (filler == held_valid_q);
      held_letter_d = plain_letter_i;
      prev_valid_d  = !word_end_i;
      prev_letter_d = word_end_i ? '0 : plain_letter_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_letter_q <= '0;
      held_valid_q  <= 1'b0;
      prev_letter_q <= '0;
      prev_valid_q  <= 1'b0;
    end else begin
      held_letter_q <= held_letter_d;
      held_valid_q  <= held_valid_d;
      prev_letter_q <= prev_letter_d;
      prev_valid_q  <= prev_valid_d;
    end
  end

  // ---- pair queue ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
    end else if (in_accept) begin
      pend_cnt_q <= npairs;
    end else if (move) begin
      pend_cnt_q <= pend_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_q[0] <= pair0;
      pend_q[1] <= pair1;
    end else if (move) begin
      // advance the second pair to the head
      pend_q[0] <= pend_q[1];
    end
  end

  // ---- enciphering into the output register ----
  assign head_cipher = pfe_pkg::encipher(square_q, pend_q[0].a, pend_q[0].b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= 1'b0;
    end else if (cipher_free) begin
      out_valid_q <= move;
      out_idx_q   <= 1'b0;
    end else if (!out_stall_i) begin
      out_idx_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_x_q    <= head_cipher.x;
      out_y_q    <= head_cipher.y;
      out_last_q <= pend_q[0].last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_letter_o = out_idx_q ? out_y_q : out_x_q;
  assign last_of_word_o  = out_idx_q & out_last_q;

  // ---- assertions ----
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd3)
    else $error("pair queue count out of range");

  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (pend_cnt_q == 2'd0) || ((pend_cnt_q == 2'd1) && move))
    else $error("letter taken while pair queue still busy");

  a_word_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && word_end_i) |=> !held_valid_q && !prev_valid_q)
    else $error("half pair survived a word end");

  a_move_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q && !out_idx_q)
    else $error("pair left the queue but output register not loaded");

endmodule
